// ----- src/vsru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsru_pkg
// Shared types, codes, timing constants and scroll helpers of the video
// scroll register unit.
// ----------------------------------------------------------------------------
package vsru_pkg;

    // sprite store depth, a power of two from 64 to 256
    localparam int SPRITE_BYTES = 256;
    localparam int SPR_AW       = $clog2(SPRITE_BYTES);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;

    typedef logic [1:0] req_t;
    localparam req_t REQ_TICK  = 2'd0;
    localparam req_t REQ_READ  = 2'd1;
    localparam req_t REQ_WRITE = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_CTRL   = 3'd0;
    localparam reg_idx_t REG_MASK   = 3'd1;
    localparam reg_idx_t REG_STATUS = 3'd2;
    localparam reg_idx_t REG_OAMADR = 3'd3;
    localparam reg_idx_t REG_OAMDAT = 3'd4;
    localparam reg_idx_t REG_SCROLL = 3'd5;
    localparam reg_idx_t REG_ADDR   = 3'd6;
    localparam reg_idx_t REG_DATA   = 3'd7;

    localparam logic [8:0] DOTS_PER_LINE = 9'd341;
    localparam logic [8:0] DOT_INC_Y     = 9'd256;
    localparam logic [8:0] DOT_COPY_X    = 9'd257;
    localparam logic [8:0] DOT_PREF_LO   = 9'd321;
    localparam logic [8:0] DOT_PREF_HI   = 9'd336;
    localparam logic [8:0] DOT_COPY_Y_LO = 9'd280;
    localparam logic [8:0] DOT_COPY_Y_HI = 9'd304;

    localparam logic signed [9:0] LINE_PRE     = -10'sd1;
    localparam logic signed [9:0] LINE_VISIBLE = 10'sd240;
    localparam logic signed [9:0] LINE_VBLANK  = 10'sd241;
    localparam logic signed [9:0] LINE_WRAP    = 10'sd261;

    localparam logic [13:0] PALETTE_BASE = 14'h3F00;
    localparam logic [2:0]  STATUS_RESET = 3'b101;
    localparam logic [4:0]  COARSE_MAX   = 5'd31;
    localparam logic [4:0]  COARSE_Y_END = 5'd29;
    localparam logic [2:0]  FINE_Y_MAX   = 3'd7;
    localparam logic [14:0] COPY_X_MASK  = 15'h041F;
    localparam logic [14:0] COPY_Y_MASK  = 15'h7BE0;

    typedef struct packed {
        logic        mem_sel;
        logic [7:0]  rd;
        logic        vw;
        logic [13:0] va;
        logic [7:0]  vwd;
        logic        nmi;
        logic        fdone;
        logic [9:0]  line;
        logic [8:0]  dot;
        logic [14:0] scroll;
    } result_t;

    function automatic logic [14:0] scroll_inc_x(input logic [14:0] s);
        logic [14:0] r;
        r = s;
        if (s[4:0] == COARSE_MAX)
        begin
            r[10] = ~s[10];
        end
        r[4:0] = s[4:0] + 5'd1;
        return r;
    endfunction

    function automatic logic [14:0] scroll_inc_y(input logic [14:0] s);
        logic [14:0] r;
        logic [4:0]  cy;
        r  = s;
        cy = s[9:5];
        if (s[14:12] != FINE_Y_MAX)
        begin
            r[14:12] = s[14:12] + 3'd1;
        end
        else
        begin
            r[14:12] = 3'd0;
            if (cy == COARSE_Y_END)
            begin
                cy    = 5'd0;
                r[11] = ~s[11];
            end
            else
            begin
                cy = cy + 5'd1;
            end
            r[9:5] = cy;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/vsru_oam_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsru_oam_ram
// Sprite attribute store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module vsru_oam_ram (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic                      re,
    input  wire logic [vsru_pkg::SPR_AW-1:0] addr,
    input  wire logic [7:0]                wdata,
    output logic      [7:0]                rdata
);
    import vsru_pkg::*;

    logic [7:0] mem [SPRITE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- src/video_scroll_register_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_scroll_register_unit
// Register file and scroll timing of a tile video unit.
//
// Input beats carry one request each: a dot tick, a register read or a
// register write (kind in s_tuser). Every beat yields exactly one output beat
// with the read byte, the video memory access, NMI and frame flags, and the
// dot, line and scroll address after the request.
// Each output beat is registered from its accepted input beat. Throughput is
// one beat per cycle while the receiver keeps up: all register state updates
// in the accept cycle, and the sprite store, a one-port memory with registered
// read, is read in that same cycle so its byte lands with the output register.
// When the receiver stalls the output register holds its beat and s_tready
// drops until it is taken; the beat is replaced in the cycle it is taken.
// Reset clears all state registers, sets the vblank and overflow status bits
// and puts the counters at line 0, dot 0. The sprite store is not cleared and
// no clearing pass runs; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module video_scroll_register_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // reg_index[2:0], write_data[10:3], vram_byte[18:11], zero[23:19]
    input  wire logic [vsru_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // read_data[7:0], vram_write[8], vram_addr[22:9], vram_wdata[30:23],
    // nmi_pulse[31], frame_done[32], cur_line[42:33], cur_dot[51:43],
    // scroll_addr[66:52], zero[71:67]
    output logic      [vsru_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import vsru_pkg::*;

    logic              accept;
    req_t              req;
    reg_idx_t          ridx;
    logic [7:0]        wd;
    logic [7:0]        vb;
    logic              ren;

    logic [7:0]        ctrl_reg,    ctrl_next;
    logic [7:0]        mask_reg,    mask_next;
    logic [2:0]        status_reg,  status_next;
    logic [14:0]       cur_reg,     cur_next;
    logic [14:0]       tmp_reg,     tmp_next;
    logic [2:0]        finex_reg,   finex_next;
    logic              toggle_reg,  toggle_next;
    logic [7:0]        rbuf_reg,    rbuf_next;
    logic [7:0]        saddr_reg,   saddr_next;
    logic [8:0]        dot_reg,     dot_next;
    logic signed [9:0] line_reg,    line_next;
    logic              odd_reg,     odd_next;
    logic              ovalid_reg,  ovalid_next;
    result_t           res_reg,     res_next;

    logic              oam_we;
    logic              oam_re;
    logic [7:0]        oam_rdata;
    logic [8:0]        dot_t;
    logic [8:0]        dot_inc;
    logic [14:0]       cur_t;

    assign req      = s_tuser;
    assign ridx     = s_tdata[2:0];
    assign wd       = s_tdata[10:3];
    assign vb       = s_tdata[18:11];
    assign s_tready = ~ovalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign ren      = mask_reg[3] | mask_reg[4];

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        cur_next    = cur_reg;
        tmp_next    = tmp_reg;
        finex_next  = finex_reg;
        toggle_next = toggle_reg;
        rbuf_next   = rbuf_reg;
        saddr_next  = saddr_reg;
        dot_next    = dot_reg;
        line_next   = line_reg;
        odd_next    = odd_reg;
        oam_we      = 1'b0;
        oam_re      = 1'b0;
        dot_t       = dot_reg;
        dot_inc     = 9'd0;
        cur_t       = cur_reg;
        res_next    = '0;

        unique case (req)
            REQ_TICK:
            begin
                if (line_reg >= LINE_PRE && line_reg < LINE_VISIBLE)
                begin
                    if (ren && odd_reg && dot_t == 9'd0 && line_reg == 10'sd0)
                    begin
                        dot_t = 9'd1;
                    end
                    if (dot_t == 9'd1 && line_reg == LINE_PRE)
                    begin
                        status_next = 3'b000;
                    end
                    if (ren && ((dot_t >= 9'd1 && dot_t <= DOT_COPY_X) ||
                                (dot_t >= DOT_PREF_LO && dot_t <= DOT_PREF_HI)))
                    begin
                        if (dot_t[2:0] == 3'd0)
                        begin
                            cur_t = scroll_inc_x(cur_t);
                        end
                        if (dot_t == DOT_INC_Y)
                        begin
                            cur_t = scroll_inc_y(cur_t);
                        end
                        if (dot_t == DOT_COPY_X)
                        begin
                            cur_t = (cur_t & ~COPY_X_MASK) | (tmp_reg & COPY_X_MASK);
                        end
                    end
                    if (ren && line_reg == LINE_PRE &&
                        dot_t >= DOT_COPY_Y_LO && dot_t <= DOT_COPY_Y_HI)
                    begin
                        cur_t = (cur_t & ~COPY_Y_MASK) | (tmp_reg & COPY_Y_MASK);
                    end
                end
                if (dot_t == 9'd1 && line_reg == LINE_VBLANK)
                begin
                    status_next[2] = 1'b1;
                    res_next.nmi   = ctrl_reg[7];
                end
                cur_next = cur_t;
                dot_inc  = dot_t + 9'd1;
                if (dot_inc >= DOTS_PER_LINE)
                begin
                    dot_next  = 9'd0;
                    line_next = line_reg + 10'sd1;
                    if (line_reg + 10'sd1 >= LINE_WRAP)
                    begin
                        line_next      = LINE_PRE;
                        res_next.fdone = 1'b1;
                        odd_next       = ~odd_reg;
                    end
                end
                else
                begin
                    dot_next = dot_inc;
                end
            end
            REQ_READ:
            begin
                unique case (ridx)
                    REG_STATUS:
                    begin
                        res_next.rd    = {status_reg, 5'b00000};
                        status_next[2] = 1'b0;
                        toggle_next    = 1'b0;
                    end
                    REG_OAMDAT:
                    begin
                        oam_re           = 1'b1;
                        res_next.mem_sel = 1'b1;
                    end
                    REG_DATA:
                    begin
                        res_next.va = cur_reg[13:0];
                        if (cur_reg[13:0] < PALETTE_BASE)
                        begin
                            res_next.rd = rbuf_reg;
                            rbuf_next   = vb;
                        end
                        else
                        begin
                            res_next.rd = vb;
                        end
                        cur_next = cur_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_WRITE:
            begin
                unique case (ridx)
                    REG_CTRL:
                    begin
                        ctrl_next       = wd;
                        tmp_next[11:10] = wd[1:0];
                    end
                    REG_MASK:
                    begin
                        mask_next = wd;
                    end
                    REG_OAMADR:
                    begin
                        saddr_next = wd;
                    end
                    REG_OAMDAT:
                    begin
                        oam_we     = 1'b1;
                        saddr_next = saddr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            tmp_next[4:0] = wd[7:3];
                            finex_next    = wd[2:0];
                        end
                        else
                        begin
                            tmp_next[9:5]   = wd[7:3];
                            tmp_next[14:12] = wd[2:0];
                        end
                        toggle_next = ~toggle_reg;
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_reg)
                        begin
                            tmp_next = {1'b0, wd[5:0], tmp_reg[7:0]};
                        end
                        else
                        begin
                            tmp_next = {tmp_reg[14:8], wd};
                            cur_next = {tmp_reg[14:8], wd};
                        end
                        toggle_next = ~toggle_reg;
                    end
                    REG_DATA:
                    begin
                        res_next.vw  = 1'b1;
                        res_next.va  = cur_reg[13:0];
                        res_next.vwd = wd;
                        cur_next     = cur_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res_next.line   = line_next;
        res_next.dot    = dot_next;
        res_next.scroll = cur_next;

        ovalid_next = ovalid_reg & ~m_tready;
        if (accept)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= 8'd0;
            mask_reg   <= 8'd0;
            status_reg <= STATUS_RESET;
            cur_reg    <= 15'd0;
            tmp_reg    <= 15'd0;
            finex_reg  <= 3'd0;
            toggle_reg <= 1'b0;
            rbuf_reg   <= 8'd0;
            saddr_reg  <= 8'd0;
            dot_reg    <= 9'd0;
            line_reg   <= 10'sd0;
            odd_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (accept)
            begin
                ctrl_reg   <= ctrl_next;
                mask_reg   <= mask_next;
                status_reg <= status_next;
                cur_reg    <= cur_next;
                tmp_reg    <= tmp_next;
                finex_reg  <= finex_next;
                toggle_reg <= toggle_next;
                rbuf_reg   <= rbuf_next;
                saddr_reg  <= saddr_next;
                dot_reg    <= dot_next;
                line_reg   <= line_next;
                odd_reg    <= odd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    vsru_oam_ram u_oam (
        .clk   (clk),
        .we    (oam_we & accept),
        .re    (oam_re & accept),
        .addr  (saddr_reg[SPR_AW-1:0]),
        .wdata (wd),
        .rdata (oam_rdata)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {5'd0, res_reg.scroll, res_reg.dot, res_reg.line,
                       res_reg.fdone, res_reg.nmi, res_reg.vwd, res_reg.va,
                       res_reg.vw, (res_reg.mem_sel ? oam_rdata : res_reg.rd)};

    // fine X is kept for the pixel pipeline, which is outside this block
    logic unused_finex;
    assign unused_finex = ^finex_reg;

endmodule
`default_nettype wire

// ----- test/scroll_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scroll_unit_checker
// Watches both stream channels of the video scroll register unit. Every
// accepted request beat is run through a local model of the registers, the
// dot and line counters and the scroll address logic. The predicted output
// beat is queued, and each accepted output beat is compared field by field
// with the oldest one in the queue.
// ----------------------------------------------------------------------------
module scroll_unit_checker
    import vsru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     results_pending,
    output int                     results_checked,
    output int                     nmi_pulses,
    output int                     frame_wraps
);

    typedef struct packed {
        logic [4:0]  pad;
        logic [14:0] scroll;
        logic [8:0]  dot;
        logic [9:0]  line;
        logic        fdone;
        logic        nmi;
        logic [7:0]  vwd;
        logic [13:0] va;
        logic        vw;
        logic [7:0]  rd;
    } unit_beat_t;

    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  rbuf_q;
    logic [7:0]  oam_ptr_q;
    logic [2:0]  status_q;
    logic [2:0]  fine_x_q;
    logic [14:0] v_q;
    logic [14:0] t_q;
    logic        toggle_q;
    logic        odd_q;
    logic [8:0]  dot_q;
    int          line_q;
    logic [7:0]  oam_mem [SPRITE_BYTES];

    unit_beat_t  pending_outputs [$];
    unit_beat_t  got;
    unit_beat_t  want;

    function automatic logic [14:0] coarse_x_step(input logic [14:0] a);
        return {a[14:11], a[10] ^ (a[4:0] == 5'd31), a[9:5], a[4:0] + 5'd1};
    endfunction

    function automatic logic [14:0] fine_y_step(input logic [14:0] a);
        logic [4:0] cy;
        if (a[14:12] != 3'd7)
            return {a[14:12] + 3'd1, a[11:0]};
        cy = (a[9:5] == 5'd29) ? 5'd0 : a[9:5] + 5'd1;
        return {3'd0, a[11] ^ (a[9:5] == 5'd29), a[10], cy, a[4:0]};
    endfunction

    task automatic step_scroll_unit(input req_t req, input reg_idx_t idx,
                                    input logic [7:0] wd, input logic [7:0] vb,
                                    output unit_beat_t res);
        logic ren;
        res = '0;
        ren = mask_q[3] | mask_q[4];
        case (req)
        REQ_TICK:
        begin
            if (line_q >= -1 && line_q < 240)
            begin
                // odd frames skip dot 0 of line 0 while rendering
                if (ren && odd_q && dot_q == 9'd0 && line_q == 0)
                    dot_q = 9'd1;
                if (dot_q == 9'd1 && line_q == -1)
                    status_q = 3'b000;
                if (ren && ((dot_q >= 9'd1 && dot_q <= 9'd257) ||
                            (dot_q >= 9'd321 && dot_q <= 9'd336)))
                begin
                    if (dot_q[2:0] == 3'd0)
                        v_q = coarse_x_step(v_q);
                    if (dot_q == 9'd256)
                        v_q = fine_y_step(v_q);
                    if (dot_q == 9'd257)
                        v_q = (v_q & ~15'h041F) | (t_q & 15'h041F);
                end
                if (ren && line_q == -1 && dot_q >= 9'd280 && dot_q <= 9'd304)
                    v_q = (v_q & ~15'h7BE0) | (t_q & 15'h7BE0);
            end
            if (dot_q == 9'd1 && line_q == 241)
            begin
                status_q[2] = 1'b1;
                res.nmi = ctrl_q[7];
            end
            dot_q = dot_q + 9'd1;
            if (dot_q >= 9'd341)
            begin
                dot_q = 9'd0;
                line_q = line_q + 1;
                if (line_q >= 261)
                begin
                    line_q = -1;
                    res.fdone = 1'b1;
                    odd_q = ~odd_q;
                end
            end
        end
        REQ_READ:
        begin
            case (idx)
            REG_STATUS:
            begin
                res.rd = {status_q, 5'd0};
                status_q[2] = 1'b0;
                toggle_q = 1'b0;
            end
            REG_OAMDAT:
                res.rd = oam_mem[oam_ptr_q % SPRITE_BYTES];
            REG_DATA:
            begin
                res.va = v_q[13:0];
                if (v_q[13:0] < 14'h3F00)
                begin
                    res.rd = rbuf_q;
                    rbuf_q = vb;
                end
                else
                    res.rd = vb;
                v_q = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
            end
            default: ;
            endcase
        end
        REQ_WRITE:
        begin
            case (idx)
            REG_CTRL:
            begin
                ctrl_q = wd;
                t_q[11:10] = wd[1:0];
            end
            REG_MASK:
                mask_q = wd;
            REG_OAMADR:
                oam_ptr_q = wd;
            REG_OAMDAT:
            begin
                oam_mem[oam_ptr_q % SPRITE_BYTES] = wd;
                oam_ptr_q = oam_ptr_q + 8'd1;
            end
            REG_SCROLL:
            begin
                if (!toggle_q)
                begin
                    t_q[4:0] = wd[7:3];
                    fine_x_q = wd[2:0];
                end
                else
                begin
                    t_q[9:5] = wd[7:3];
                    t_q[14:12] = wd[2:0];
                end
                toggle_q = ~toggle_q;
            end
            REG_ADDR:
            begin
                if (!toggle_q)
                    t_q[14:8] = {1'b0, wd[5:0]};
                else
                begin
                    t_q[7:0] = wd;
                    v_q = t_q;
                end
                toggle_q = ~toggle_q;
            end
            REG_DATA:
            begin
                res.vw = 1'b1;
                res.va = v_q[13:0];
                res.vwd = wd;
                v_q = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
            end
            default: ;
            endcase
        end
        default: ;
        endcase
        res.line = line_q[9:0];
        res.dot = dot_q;
        res.scroll = v_q;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ctrl_q = 8'd0;
            mask_q = 8'd0;
            rbuf_q = 8'd0;
            oam_ptr_q = 8'd0;
            status_q = 3'b101;
            fine_x_q = 3'd0;
            v_q = 15'd0;
            t_q = 15'd0;
            toggle_q = 1'b0;
            odd_q = 1'b0;
            dot_q = 9'd0;
            line_q = 0;
            pending_outputs.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = unit_beat_t'(m_tdata);
                if (pending_outputs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 40)
                        $error("output beat 0x%0h with no request outstanding", m_tdata);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    results_checked++;
                    check_field("read_data", want.rd, got.rd);
                    check_field("vram_write", want.vw, got.vw);
                    check_field("vram_addr", want.va, got.va);
                    check_field("vram_wdata", want.vwd, got.vwd);
                    check_field("nmi_pulse", want.nmi, got.nmi);
                    check_field("frame_done", want.fdone, got.fdone);
                    check_field("cur_line", want.line, got.line);
                    check_field("cur_dot", want.dot, got.dot);
                    check_field("scroll_addr", want.scroll, got.scroll);
                    check_field("padding", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready)
            begin
                step_scroll_unit(req_t'(s_tuser), reg_idx_t'(s_tdata[2:0]),
                                 s_tdata[10:3], s_tdata[18:11], want);
                nmi_pulses += want.nmi;
                frame_wraps += want.fdone;
                pending_outputs.push_back(want);
            end
        end
        results_pending = pending_outputs.size();
    end

endmodule

// ----- test/video_scroll_register_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scroll_register_unit_tb
// Drives register reads, register writes and dot ticks into the video scroll
// register unit: a directed opening, random register traffic under three
// stall patterns, then a short run of dot ticks with rendering and NMI on
// and sparse register accesses.
// Checking is done by scroll_unit_checker.
// ----------------------------------------------------------------------------
module video_scroll_register_unit_tb;
    import vsru_pkg::*;

    localparam req_t REQ_UNUSED  = 2'd3;
    localparam int   TIMEOUT_NS  = 200_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   requests_sent = 0;
    logic [7:0] oam_ptr = 8'd0;
    bit   oam_written [SPRITE_BYTES];

    int   mismatch_count;
    int   results_pending;
    int   results_checked;
    int   nmi_pulses;
    int   frame_wraps;

    video_scroll_register_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scroll_unit_checker scroll_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked),
        .nmi_pulses      (nmi_pulses),
        .frame_wraps     (frame_wraps)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic send_request(input req_t req, input reg_idx_t idx,
                                input logic [7:0] wd, input logic [7:0] vb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'd0, vb, wd, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
        if (req == REQ_WRITE && idx == REG_OAMADR)
            oam_ptr = wd;
        if (req == REQ_WRITE && idx == REG_OAMDAT)
        begin
            oam_written[oam_ptr % SPRITE_BYTES] = 1'b1;
            oam_ptr = oam_ptr + 8'd1;
        end
    endtask

    task automatic random_access();
        req_t     req;
        reg_idx_t idx;
        req = $urandom_range(1) ? REQ_WRITE : REQ_READ;
        idx = reg_idx_t'($urandom_range(7));
        // never read a sprite entry that was not written
        if (req == REQ_READ && idx == REG_OAMDAT && !oam_written[oam_ptr % SPRITE_BYTES])
            req = REQ_WRITE;
        send_request(req, idx, rand_byte(), rand_byte());
    endtask

    task automatic random_traffic(input int count);
        int         stop_at;
        int         pick;
        logic [7:0] base;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_request(REQ_TICK, reg_idx_t'($urandom_range(7)),
                             rand_byte(), rand_byte());
            else if (pick < 44)
            begin
                send_request(REQ_READ, REG_STATUS, rand_byte(), rand_byte());
                base = rand_byte();
                if ($urandom_range(3) == 0)
                    base = base | 8'h3F;
                send_request(REQ_WRITE, REG_ADDR, base, rand_byte());
                send_request(REQ_WRITE, REG_ADDR, rand_byte(), rand_byte());
                repeat ($urandom_range(1, 4))
                    send_request($urandom_range(1) ? REQ_READ : REQ_WRITE, REG_DATA,
                                 rand_byte(), rand_byte());
            end
            else if (pick < 52)
            begin
                send_request(REQ_READ, REG_STATUS, rand_byte(), rand_byte());
                send_request(REQ_WRITE, REG_SCROLL, rand_byte(), rand_byte());
                send_request(REQ_WRITE, REG_SCROLL, rand_byte(), rand_byte());
            end
            else if (pick < 60)
            begin
                base = rand_byte();
                send_request(REQ_WRITE, REG_OAMADR, base, rand_byte());
                repeat ($urandom_range(1, 4))
                    send_request(REQ_WRITE, REG_OAMDAT, rand_byte(), rand_byte());
                send_request(REQ_WRITE, REG_OAMADR, base, rand_byte());
                send_request(REQ_READ, REG_OAMDAT, rand_byte(), rand_byte());
            end
            else
                random_access();
        end
    endtask

    task automatic frame_sweep(input int ticks);
        repeat (ticks)
        begin
            if ($urandom_range(299) == 0)
                random_access();
            else
                send_request(REQ_TICK, REG_CTRL, 8'h00, 8'h00);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 62;
        send_request(REQ_READ, REG_STATUS, 8'h00, 8'h00);
        send_request(REQ_READ, REG_STATUS, 8'hFF, 8'hFF);
        send_request(REQ_WRITE, REG_STATUS, 8'hFF, 8'h00);
        send_request(REQ_UNUSED, REG_DATA, 8'hFF, 8'hFF);
        send_request(REQ_READ, REG_CTRL, 8'h00, 8'h00);
        send_request(REQ_READ, REG_MASK, 8'h00, 8'h00);
        send_request(REQ_READ, REG_OAMADR, 8'h00, 8'h00);
        send_request(REQ_READ, REG_SCROLL, 8'h00, 8'h00);
        send_request(REQ_READ, REG_ADDR, 8'h00, 8'h00);
        send_request(REQ_WRITE, REG_CTRL, 8'hFF, 8'h00);
        send_request(REQ_WRITE, REG_SCROLL, 8'hFF, 8'h00);
        send_request(REQ_WRITE, REG_SCROLL, 8'h00, 8'h00);
        send_request(REQ_WRITE, REG_ADDR, 8'hFF, 8'h00);
        send_request(REQ_WRITE, REG_ADDR, 8'h00, 8'h00);
        send_request(REQ_READ, REG_DATA, 8'h00, 8'hFF);
        send_request(REQ_WRITE, REG_CTRL, 8'h00, 8'h00);
        send_request(REQ_WRITE, REG_ADDR, 8'h3E, 8'h00);
        send_request(REQ_WRITE, REG_ADDR, 8'hFF, 8'h00);
        send_request(REQ_READ, REG_DATA, 8'h00, 8'h00);
        send_request(REQ_READ, REG_DATA, 8'h00, 8'hA5);
        send_request(REQ_WRITE, REG_DATA, 8'hFF, 8'h00);
        send_request(REQ_WRITE, REG_OAMADR, 8'hFF, 8'h00);
        send_request(REQ_WRITE, REG_OAMDAT, 8'h5A, 8'h00);
        send_request(REQ_WRITE, REG_OAMADR, 8'hFF, 8'h00);
        send_request(REQ_READ, REG_OAMDAT, 8'h00, 8'h00);
        send_request(REQ_WRITE, REG_MASK, 8'h18, 8'h00);
        send_request(REQ_TICK, REG_DATA, 8'hFF, 8'hFF);
        send_request(REQ_TICK, REG_CTRL, 8'h00, 8'h00);
        send_request(REQ_WRITE, REG_MASK, 8'h00, 8'h00);
        random_traffic(210);

        send_idle_pct = 62;
        recv_idle_pct = 19;
        random_traffic(210);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(210);
        send_request(REQ_WRITE, REG_MASK, 8'h1E, 8'h00);
        send_request(REQ_WRITE, REG_CTRL, 8'h80, 8'h00);
        frame_sweep(40);
        s_tvalid <= 1'b0;

        while (results_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests sent, %0d output beats checked", requests_sent,
                 results_checked);
        $display("frame wraps seen: %0d, NMI pulses seen: %0d", frame_wraps, nmi_pulses);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
